>>> rtl/mandelbrot_escape_time_macros.svh
// ---------------------------------------------------------------------------
// Mandelbrot escape-time macros
// Assertion shorthands used by the escape-time engine. Both sample on the
// rising edge of clk and are switched off while rst is high.
// ---------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/met_pkg.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time package
// Word types, register indexes, reset values and sequencer states shared by
// the escape-time engine and its environment.
// ---------------------------------------------------------------------------
package met_pkg;

  localparam int FRAC_BITS  = 24;
  localparam int COORD_BITS = 12;
  localparam int LIMIT_W    = 16;
  localparam int ITER_W     = LIMIT_W + 1;
  localparam int RADIUS_W   = 7;
  localparam int STEP_W     = 31;
  localparam int CFG_IDX_W  = 3;

  localparam logic [STEP_W-1:0]     STEP_RESET   = STEP_W'(43691);
  localparam logic [COORD_BITS-1:0] HALF_W_RESET = COORD_BITS'(960);
  localparam logic [COORD_BITS-1:0] HALF_H_RESET = COORD_BITS'(540);
  localparam logic [LIMIT_W-1:0]    LIMIT_RESET  = LIMIT_W'(100);
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET = RADIUS_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_RE  = 3'd0,
    REG_CENTER_IM  = 3'd1,
    REG_STEP_RE    = 3'd2,
    REG_STEP_IM    = 3'd3,
    REG_HALF_WIDTH = 3'd4,
    REG_HALF_HGT   = 3'd5,
    REG_ITER_LIMIT = 3'd6,
    REG_RADIUS_SQ  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_CSET,
    S_MUL,
    S_UPD,
    S_DONE
  } met_state_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic               inside_res;
    logic signed [31:0] final_re;
    logic signed [31:0] final_im;
  } result_t;

endpackage

>>> rtl/mandelbrot_escape_time.sv
// ---------------------------------------------------------------------------
// Mandelbrot escape-time engine
// Maps one pixel to a point c of the complex plane and iterates z = z*z + c
// in Q8.24 until |z|^2 reaches the squared escape radius or the iteration limit.
// ---------------------------------------------------------------------------
// One pixel is worked on at a time. Its result word is loaded once z escapes
// or the count reaches iteration_limit, and the next pixel is taken in the
// cycle after the word is loaded. A word still unread in the output register
// holds the finished pixel in S_DONE until it is read. The work runs on the
// bank of three signed 32x32 multipliers, which is shared between the
// coordinate mapping and every complex square: the S_MUL state forms the
// products, the S_UPD state after it tests escape and updates z. The finished
// result sits in an output register, so a new pixel is taken while the
// previous result waits to be read. Config registers are written through the
// cfg port, which is always ready.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  met_pkg::pixel_t                  pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output met_pkg::result_t                 result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [met_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import met_pkg::*;

  localparam int WIDE = 66;
  localparam int DW   = COORD_BITS + 1;

  // Configuration registers.
  logic signed [31:0]     center_re;
  logic signed [31:0]     center_im;
  logic [STEP_W-1:0]      step_re;
  logic [STEP_W-1:0]      step_im;
  logic [COORD_BITS-1:0]  half_width;
  logic [COORD_BITS-1:0]  half_height;
  logic [LIMIT_W-1:0]     iteration_limit;
  logic [RADIUS_W-1:0]    escape_radius_sq;

  met_state_t state, state_next;

  logic signed [DW-1:0]   d_re;
  logic signed [DW-1:0]   d_im;
  logic signed [31:0]     c_re;
  logic signed [31:0]     c_im;
  logic signed [31:0]     a;
  logic signed [31:0]     b;
  logic [ITER_W-1:0]      iter;
  logic signed [63:0]     p0;
  logic signed [63:0]     p1;
  logic signed [63:0]     p2;

  logic                   pixel_take;
  logic                   out_free;
  logic                   map_sel;
  logic                   prod_load;
  logic                   result_load;

  logic signed [31:0]     m0a, m0b, m1a, m1b;
  logic signed [63:0]     sa, sb, xab;
  logic [64:0]            sum_sq;
  logic [64:0]            bound;
  logic                   esc_ok;
  logic                   go;
  logic signed [31:0]     new_a;
  logic signed [31:0]     new_b;
  logic signed [31:0]     map_re;
  logic signed [31:0]     map_im;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE-1:0] v);
    logic [WIDE-32:0] hi;
    hi = v[WIDE-1:31];
    if ((&hi) || !(|hi)) begin
      return v[31:0];
    end else if (v[WIDE-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7fff_ffff;
    end
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re        <= '0;
      center_im        <= '0;
      step_re          <= STEP_RESET;
      step_im          <= STEP_RESET;
      half_width       <= HALF_W_RESET;
      half_height      <= HALF_H_RESET;
      iteration_limit  <= LIMIT_RESET;
      escape_radius_sq <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_RE:  center_re        <= cfg_data;
        REG_CENTER_IM:  center_im        <= cfg_data;
        REG_STEP_RE:    step_re          <= cfg_data[STEP_W-1:0];
        REG_STEP_IM:    step_im          <= cfg_data[STEP_W-1:0];
        REG_HALF_WIDTH: half_width       <= cfg_data[COORD_BITS-1:0];
        REG_HALF_HGT:   half_height      <= cfg_data[COORD_BITS-1:0];
        REG_ITER_LIMIT: iteration_limit  <= cfg_data[LIMIT_W-1:0];
        REG_RADIUS_SQ:  escape_radius_sq <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !result_valid || !result_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (pixel_valid) state_next = S_MAP;
      S_MAP:  state_next = S_CSET;
      S_CSET: state_next = S_MUL;
      S_MUL:  state_next = S_UPD;
      S_UPD:  state_next = (esc_ok && go) ? S_MUL : S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pixel_stall = 1'b1;
    map_sel     = 1'b0;
    prod_load   = 1'b0;
    result_load = 1'b0;
    case (state)
      S_IDLE: pixel_stall = 1'b0;
      S_MAP: begin
        map_sel   = 1'b1;
        prod_load = 1'b1;
      end
      S_MUL:  prod_load = 1'b1;
      S_DONE: result_load = out_free;
      default: ;
    endcase
  end

  assign pixel_take = pixel_valid && !pixel_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier bank: pixel offsets times step while mapping, then the
  // three products of the complex square.
  assign m0a = map_sel ? 32'(d_re) : a;
  assign m0b = map_sel ? $signed({1'b0, step_re}) : a;
  assign m1a = map_sel ? 32'(d_im) : b;
  assign m1b = map_sel ? $signed({1'b0, step_im}) : b;

  always_ff @(posedge clk) begin
    if (prod_load) begin
      p0 <= m0a * m0b;
      p1 <= m1a * m1b;
      p2 <= a * b;
    end
  end

  // Arithmetic shifts floor toward minus infinity.
  assign sa     = p0 >>> FRAC_BITS;
  assign sb     = p1 >>> FRAC_BITS;
  assign xab    = p2 >>> (FRAC_BITS - 1);
  assign sum_sq = {1'b0, sa} + {1'b0, sb};
  assign bound  = 65'(escape_radius_sq) << FRAC_BITS;
  assign esc_ok = sum_sq < bound;
  assign go     = iter < {1'b0, iteration_limit};
  assign new_a  = sat32(WIDE'(sa) - WIDE'(sb) + WIDE'(c_re));
  assign new_b  = sat32(WIDE'(xab) + WIDE'(c_im));
  assign map_re = sat32(WIDE'(p0) + WIDE'(center_re));
  assign map_im = sat32(WIDE'(p1) + WIDE'(center_im));

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      d_re <= $signed({1'b0, pixel.pixel_x}) - $signed({1'b0, half_width});
      d_im <= $signed({1'b0, pixel.pixel_y}) - $signed({1'b0, half_height});
    end
    if (state == S_CSET) begin
      c_re <= map_re;
      c_im <= map_im;
      a    <= '0;
      b    <= '0;
    end else if (state == S_UPD && esc_ok && go) begin
      a <= new_a;
      b <= new_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
    end else if (state == S_CSET) begin
      iter <= '0;
    end else if (state == S_UPD && esc_ok) begin
      iter <= iter + ITER_W'(1);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (result_load) begin
      result.iterations <= iter;
      result.inside_res <= (iter >= {1'b0, iteration_limit});
      result.final_re   <= a;
      result.final_im   <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  `MET_ASSERT_SAME(a_iter_bound, state == S_UPD,
                   iter <= {1'b0, iteration_limit}, "count ran past the limit")
  `MET_ASSERT_NEXT(a_start_zero, state == S_CSET,
                   a == '0 && b == '0 && iter == '0, "z or count not cleared at start")
  `MET_ASSERT_NEXT(a_done_loads, state == S_DONE && out_free,
                   result_valid && state == S_IDLE, "finished word not loaded")
  `MET_ASSERT_SAME(a_inside_flag, result_valid,
                   result.inside_res == (result.iterations >= {1'b0, iteration_limit}),
                   "inside flag disagrees with count")

endmodule
